[design/tphb_pkg.sv]
// shared types and constants of the touch position and button hit unit
// used by tphb_ctrl, tphb_dp and touch_position_and_button_hit_unit; no dependencies
`default_nettype none

package tphb_pkg;

  // area table size and derived widths
  localparam int MAX_AREAS = 32;
  localparam int IDX_W     = (MAX_AREAS > 1) ? $clog2(MAX_AREAS) : 1;
  localparam int COUNT_W   = $clog2(MAX_AREAS + 1);

  // fixed field widths
  localparam int ADC_W    = 10;
  localparam int CORNER_W = 9;
  localparam int SCALE_W  = 16;
  localparam int POS_W    = 16;
  localparam int BTN_W    = 6;
  localparam int SLOT_W   = 5;
  localparam int ENTRY_W  = 32;

  // divide by the scale base through a reciprocal multiply;
  // exact for every product below 2**26
  localparam int SCALE_DIV   = 1000;
  localparam int RECIP_SHIFT = 36;
  localparam int MUL_A_W     = 26;
  localparam int MUL_B_W     = 27;
  localparam int PROD_W      = MUL_A_W + MUL_B_W;
  localparam logic [MUL_B_W-1:0] RECIP_MUL =
    MUL_B_W'(((64'd1 << RECIP_SHIFT) + 64'(SCALE_DIV - 1)) / 64'(SCALE_DIV));

  typedef enum logic [1:0] {
    FUNC_SAMPLE = 2'd0,
    FUNC_ADD    = 2'd1,
    FUNC_CLEAR  = 2'd2
  } func_t;

  typedef enum logic [1:0] {
    REG_OFFSET_X = 2'd0,
    REG_OFFSET_Y = 2'd1,
    REG_SCALE_X  = 2'd2,
    REG_SCALE_Y  = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_NONE    = 3'd0,
    ST_CONV    = 3'd1,
    ST_UNCAL   = 3'd2,
    ST_ADDED   = 3'd3,
    ST_FULL    = 3'd4,
    ST_CLEARED = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    MUL_SCALE_X,
    MUL_SCALE_Y,
    MUL_RECIP
  } mul_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL_X,
    S_DIV_X,
    S_MUL_Y,
    S_DIV_Y,
    S_SCAN_START,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic [CORNER_W-1:0] stop_y;
    logic [CORNER_W-1:0] stop_x;
    logic [CORNER_W-1:0] start_y;
    logic [CORNER_W-1:0] start_x;
    logic [ADC_W-1:0]    adc_y;
    logic [ADC_W-1:0]    adc_x;
    logic [1:0]          func;
  } item_t;

  typedef struct packed {
    logic [2:0]        status;
    logic [POS_W-1:0]  pos_x;
    logic [POS_W-1:0]  pos_y;
    logic [BTN_W-1:0]  button;
    logic [SLOT_W-1:0] area_slot;
  } result_t;

  // controller to datapath
  typedef struct packed {
    logic    take;
    logic    mul_en;
    mul_op_t mul_op;
    logic    px_load;
    logic    scan_start;
    logic    scan_step;
    logic    res_en;
    status_t res_code;
    logic    area_wr;
    logic    area_clr;
    logic    out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [1:0] func;
    logic       touch;
    logic       calib;
    logic       full;
    logic       scan_done;
  } sts_t;

endpackage

`default_nettype wire

[design/tphb_ctrl.sv]
// controller state machine: handshakes, item sequencing, output word valid
// depends on tphb_pkg
`default_nettype none

module tphb_ctrl (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  wire logic          out_ready,
  input  wire tphb_pkg::sts_t sts,
  output tphb_pkg::cmd_t     cmd
);
  import tphb_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) state_next = S_DECODE;
      end
      S_DECODE: begin
        if (sts.func == FUNC_SAMPLE && sts.touch && sts.calib) state_next = S_MUL_X;
        else state_next = S_DONE;
      end
      S_MUL_X:      state_next = S_DIV_X;
      S_DIV_X:      state_next = S_MUL_Y;
      S_MUL_Y:      state_next = S_DIV_Y;
      S_DIV_Y:      state_next = S_SCAN_START;
      S_SCAN_START: state_next = S_SCAN;
      S_SCAN: begin
        if (sts.scan_done) state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.mul_op   = MUL_RECIP;
    cmd.res_code = ST_NONE;
    in_ready = 1'b0;
    unique case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.take = in_valid;
      end
      S_DECODE: begin
        case (func_t'(sts.func))
          FUNC_SAMPLE: begin
            if (!sts.touch) begin
              cmd.res_en   = 1'b1;
              cmd.res_code = ST_NONE;
            end else if (!sts.calib) begin
              cmd.res_en   = 1'b1;
              cmd.res_code = ST_UNCAL;
            end
          end
          FUNC_ADD: begin
            cmd.res_en   = 1'b1;
            cmd.res_code = sts.full ? ST_FULL : ST_ADDED;
            cmd.area_wr  = !sts.full;
          end
          FUNC_CLEAR: begin
            cmd.res_en   = 1'b1;
            cmd.res_code = ST_CLEARED;
            cmd.area_clr = 1'b1;
          end
          default: begin
            cmd.res_en   = 1'b1;
            cmd.res_code = ST_NONE;
          end
        endcase
      end
      S_MUL_X: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_SCALE_X;
      end
      S_DIV_X: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_RECIP;
      end
      S_MUL_Y: begin
        cmd.mul_en  = 1'b1;
        cmd.mul_op  = MUL_SCALE_Y;
        cmd.px_load = 1'b1;
      end
      S_DIV_Y: begin
        cmd.mul_en = 1'b1;
        cmd.mul_op = MUL_RECIP;
      end
      S_SCAN_START: cmd.scan_start = 1'b1;
      S_SCAN:       cmd.scan_step  = 1'b1;
      S_DONE:       cmd.out_load   = !out_valid || out_ready;
      default: ;
    endcase
  end

  // output word valid: set on load, cleared once taken
  always_comb begin
    out_valid_next = out_valid;
    if (cmd.out_load) out_valid_next = 1'b1;
    else if (out_ready) out_valid_next = 1'b0;
  end

endmodule

`default_nettype wire

[design/tphb_dp.sv]
// datapath: config registers, input latch, shared multiplier, area table
// memory with scan, result and output registers; depends on tphb_pkg
`default_nettype none

module tphb_dp (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_we,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [15:0]           cfg_data,
  input  wire tphb_pkg::item_t       item,
  input  wire tphb_pkg::cmd_t        cmd,
  output tphb_pkg::sts_t             sts,
  output tphb_pkg::result_t          out_word
);
  import tphb_pkg::*;

  logic [ADC_W-1:0]   ofs_x, ofs_y;
  logic [SCALE_W-1:0] scale_x, scale_y;

  item_t              cur;
  logic [PROD_W-1:0]  prod;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [ADC_W-1:0]   dx, dy;

  logic [ENTRY_W-1:0] area_mem [MAX_AREAS];
  logic [ENTRY_W-1:0] rd_data;
  logic [COUNT_W-1:0] area_count;
  logic [COUNT_W-1:0] ridx;
  logic [IDX_W-1:0]   cidx;
  logic               dv;
  logic               hit;
  logic [7:0]         hx, hy;
  logic [POS_W-1:0]   py_conv;
  logic               off_screen;

  result_t            res;

  function automatic logic [POS_W-1:0] sat_quot(input logic [PROD_W-1:0] p);
    logic [PROD_W-RECIP_SHIFT-1:0] q;
    q = p[PROD_W-1:RECIP_SHIFT];
    return q[POS_W] ? {POS_W{1'b1}} : q[POS_W-1:0];
  endfunction

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      ofs_x   <= '0;
      ofs_y   <= '0;
      scale_x <= '0;
      scale_y <= '0;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_OFFSET_X: ofs_x   <= cfg_data[ADC_W-1:0];
        REG_OFFSET_Y: ofs_y   <= cfg_data[ADC_W-1:0];
        REG_SCALE_X:  scale_x <= cfg_data;
        REG_SCALE_Y:  scale_y <= cfg_data;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) cur <= item;
  end

  assign dx = cur.adc_x - ofs_x;
  assign dy = cur.adc_y - ofs_y;

  // one shared multiplier: scale product, then reciprocal of the scale base
  always_comb begin
    case (cmd.mul_op)
      MUL_SCALE_X: begin
        mul_a = MUL_A_W'(dx);
        mul_b = MUL_B_W'(scale_x);
      end
      MUL_SCALE_Y: begin
        mul_a = MUL_A_W'(dy);
        mul_b = MUL_B_W'(scale_y);
      end
      default: begin
        mul_a = prod[MUL_A_W-1:0];
        mul_b = RECIP_MUL;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mul_en) prod <= {{MUL_B_W{1'b0}}, mul_a} * {{MUL_A_W{1'b0}}, mul_b};
  end

  assign py_conv    = sat_quot(prod);
  assign off_screen = (res.pos_x[POS_W-1:9] != '0) || (py_conv[POS_W-1:9] != '0);

  // area table
  always_ff @(posedge clk) begin
    if (cmd.area_wr) begin
      area_mem[area_count[IDX_W-1:0]] <= {cur.stop_y[8:1], cur.stop_x[8:1],
                                          cur.start_y[8:1], cur.start_x[8:1]};
    end
    if (cmd.scan_step) rd_data <= area_mem[ridx[IDX_W-1:0]];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      area_count <= '0;
    end else if (cmd.area_clr) begin
      area_count <= '0;
    end else if (cmd.area_wr) begin
      area_count <= area_count + COUNT_W'(1);
    end
  end

  // scan pipeline: read issue, then compare on registered data
  always_ff @(posedge clk) begin
    if (rst) begin
      dv <= 1'b0;
    end else if (cmd.scan_start) begin
      dv <= 1'b0;
    end else if (cmd.scan_step) begin
      dv <= ridx < area_count;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      ridx <= off_screen ? area_count : '0;
    end else if (cmd.scan_step && ridx < area_count) begin
      ridx <= ridx + COUNT_W'(1);
      cidx <= ridx[IDX_W-1:0];
    end
  end

  assign hx  = res.pos_x[8:1];
  assign hy  = res.pos_y[8:1];
  assign hit = hx >= rd_data[7:0] && hx <= rd_data[23:16] &&
               hy >= rd_data[15:8] && hy <= rd_data[31:24];

  // result register
  always_ff @(posedge clk) begin
    if (cmd.res_en) begin
      res.status    <= cmd.res_code;
      res.pos_x     <= (cmd.res_code == ST_UNCAL) ? POS_W'(cur.adc_x) : '0;
      res.pos_y     <= (cmd.res_code == ST_UNCAL) ? POS_W'(cur.adc_y) : '0;
      res.button    <= '0;
      res.area_slot <= (cmd.res_code == ST_ADDED) ? SLOT_W'(area_count) : '0;
    end
    if (cmd.px_load) res.pos_x <= sat_quot(prod);
    if (cmd.scan_start) begin
      res.status    <= ST_CONV;
      res.pos_y     <= py_conv;
      res.button    <= '0;
      res.area_slot <= '0;
    end
    if (cmd.scan_step && dv && hit) res.button <= BTN_W'(cidx) + BTN_W'(1);
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_word <= res;
  end

  assign sts.func      = cur.func;
  assign sts.touch     = cur.adc_x > ofs_x && cur.adc_y > ofs_y;
  assign sts.calib     = scale_x != '0 && scale_y != '0;
  assign sts.full      = area_count == COUNT_W'(MAX_AREAS);
  assign sts.scan_done = (dv && hit) || (!dv && ridx >= area_count);

endmodule

`default_nettype wire

[design/touch_position_and_button_hit_unit.sv]
// top level of the touch position and button hit unit
// depends on tphb_pkg, tphb_ctrl and tphb_dp
`default_nettype none

// usage
//   slave stream takes one word per item; tuser carries the item kind
//   (sample, add area, clear areas), tdata the readings and area corners
//   master stream gives one word per item; tuser carries the status code,
//   tdata the position, button number and area slot
//   cfg_we/cfg_index/cfg_data write offsets and scales, only while idle
// item sequencing, one item at a time
//   add, clear, no touch and uncalibrated items go from decode straight to
//   the output; a converted sample takes the x and y multiply and divide
//   steps, then the area scan, which stops at once off screen or with an
//   empty table, else at the first hit or after the last of at most 32
//   stored areas; the next item is accepted once the word is loaded. The
//   scan reads one table entry per cycle from the single read port; both
//   axes share a multiplier (scale product, then reciprocal divide by 1000)
// reset
//   rst clears the config registers, area count and handshake state; the
//   area memory is not cleared, the count keeps unwritten entries unread
// stall
//   the output word register holds while tready is low; the next item is
//   accepted meanwhile and waits finished until the register frees

module touch_position_and_button_hit_unit (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  // input stream
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // adc_x[9:0], adc_y[19:10], start_x[28:20], start_y[37:29],
  // stop_x[46:38], stop_y[55:47]
  input  wire logic [55:0] s_axis_tdata,
  // func[1:0]
  input  wire logic [1:0]  s_axis_tuser,
  // output stream
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // pos_x[15:0], pos_y[31:16], button[37:32], area_slot[42:38], zero[47:43]
  output logic [47:0]      m_axis_tdata,
  // status[2:0]
  output logic [2:0]       m_axis_tuser
);
  import tphb_pkg::*;

  item_t   item;
  cmd_t    cmd;
  sts_t    sts;
  result_t out_word;

  // unpack the input word
  assign item.func    = s_axis_tuser;
  assign item.adc_x   = s_axis_tdata[9:0];
  assign item.adc_y   = s_axis_tdata[19:10];
  assign item.start_x = s_axis_tdata[28:20];
  assign item.start_y = s_axis_tdata[37:29];
  assign item.stop_x  = s_axis_tdata[46:38];
  assign item.stop_y  = s_axis_tdata[55:47];

  tphb_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .sts       (sts),
    .cmd       (cmd)
  );

  tphb_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .item      (item),
    .cmd       (cmd),
    .sts       (sts),
    .out_word  (out_word)
  );

  // pack the output word
  assign m_axis_tdata = {5'b0, out_word.area_slot, out_word.button,
                         out_word.pos_y, out_word.pos_x};
  assign m_axis_tuser = out_word.status;

  // a full table is never written
  a_no_add_when_full: assert property (@(posedge clk) disable iff (rst)
    cmd.area_wr |-> !sts.full)
    else $error("area written into a full table");

  // the output register is only loaded when its word is gone or leaving
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!m_axis_tvalid || m_axis_tready))
    else $error("pending output word overwritten");

  // one item in flight: no accept in the cycle after an accept
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("second item accepted while one is in flight");

endmodule

`default_nettype wire
